// ----- rtl/core/sia_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package sia_pkg;

   // Field widths on the stream ports
   localparam int ID_W        = 20;
   localparam int PAY_IO_W    = 32;
   localparam int OP_W        = 2;
   localparam int REQ_TDATA_W = 56;  // stream_id + payload, padded to whole bytes
   localparam int RSP_TDATA_W = 56;  // result_id + result_payload, padded

   // Defaults for the top-level parameters
   localparam int NUM_IDS_DEF      = 4096;
   localparam int PAYLOAD_BITS_DEF = 32;

   // Register port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [0:0] CSR_REG_BASE_ID = 1'b0;  // register index, byte address 0
   localparam logic [ID_W-1:0] BASE_ID_RESET = ID_W'(16);

   typedef enum logic [OP_W-1:0] {
      OP_ALLOC   = 2'd0,
      OP_LOOKUP  = 2'd1,
      OP_RELEASE = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_RESOLVE
   } ctrl_state_type;

   typedef struct packed {
      logic capture;  // latch the accepted request
      logic read;     // issue table and queue reads
      logic commit;   // write back and load the result register
   } cmd_type;

   typedef struct packed {
      logic out_free;  // result register empty or draining this cycle
   } status_type;

endpackage

`default_nettype wire

// ----- rtl/core/sia_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sia_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- rtl/core/sia_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sia_ctrl
   import sia_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire status_type status,
   output cmd_type         cmd
);

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_RESOLVE;
         end
         ST_RESOLVE: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_tready  = 1'b0;
      cmd.capture = 1'b0;
      cmd.read    = 1'b0;
      cmd.commit  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
         end
         ST_READ: begin
            cmd.read = 1'b1;
         end
         ST_RESOLVE: begin
            // hold until the result register can take the answer
            cmd.commit = status.out_free;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/sia_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sia_datapath
   import sia_pkg::*;
#(
   parameter int NUM_IDS      = NUM_IDS_DEF,
   parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire cmd_type             cmd,
   output status_type               status,
   input  wire op_type              req_op,
   input  wire logic [ID_W-1:0]     req_stream_id,
   input  wire logic [PAY_IO_W-1:0] req_payload,
   input  wire logic [ID_W-1:0]     base_id,
   input  wire logic                rsp_tready,
   output logic                     rsp_tvalid,
   output logic [ID_W-1:0]          rsp_result_id,
   output logic [PAY_IO_W-1:0]      rsp_result_payload,
   output logic                     rsp_ok
);

   localparam int IDX_W = $clog2(NUM_IDS);
   localparam int CNT_W = $clog2(NUM_IDS + 1);
   localparam logic [CNT_W-1:0] NUM_IDS_CNT = CNT_W'(NUM_IDS);
   localparam logic [IDX_W-1:0] LAST_IDX    = IDX_W'(NUM_IDS - 1);

   // Captured request
   op_type                  op_ff,    op_in;
   logic [ID_W-1:0]         sid_ff,   sid_in;
   logic [PAYLOAD_BITS-1:0] pay_ff,   pay_in;
   logic [IDX_W-1:0]        idx_ff,   idx_in;
   logic                    range_ff, range_in;

   // Allocator state
   logic [CNT_W-1:0] fresh_ff, fresh_in;
   logic [IDX_W-1:0] head_ff,  head_in;
   logic [IDX_W-1:0] tail_ff,  tail_in;
   logic [CNT_W-1:0] fill_ff,  fill_in;

   // Result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0]     rsp_id_ff,    rsp_id_in;
   logic [PAY_IO_W-1:0] rsp_pay_ff,   rsp_pay_in;
   logic                rsp_ok_ff,    rsp_ok_in;

   logic [ID_W-1:0]         idx_calc;
   logic [PAYLOAD_BITS-1:0] pay_trim;
   logic [PAY_IO_W-1:0]     pay_out;

   logic                    valid_rd;
   logic [PAYLOAD_BITS-1:0] pay_rd;
   logic [IDX_W-1:0]        queue_rd;

   logic                    valid_we;
   logic                    valid_wd;
   logic [IDX_W-1:0]        entry_wa;
   logic                    pay_we;
   logic                    queue_we;

   logic                    alloc_got;
   logic [IDX_W-1:0]        aidx;
   logic                    hit;
   logic                    rel_ok;

   // Fit the payload to the table width and back
   generate
      if (PAYLOAD_BITS < PAY_IO_W) begin : g_pay_narrow
         assign pay_trim = req_payload[PAYLOAD_BITS-1:0];
         assign pay_out  = {{(PAY_IO_W - PAYLOAD_BITS){1'b0}}, pay_rd};
      end else if (PAYLOAD_BITS == PAY_IO_W) begin : g_pay_equal
         assign pay_trim = req_payload;
         assign pay_out  = pay_rd;
      end else begin : g_pay_wide
         assign pay_trim = {{(PAYLOAD_BITS - PAY_IO_W){1'b0}}, req_payload};
         assign pay_out  = pay_rd[PAY_IO_W-1:0];
      end
   endgenerate

   assign idx_calc = req_stream_id - base_id;

   // Table index -> a valid bit only counts below the fresh counter
   assign hit = range_ff && (CNT_W'(idx_ff) < fresh_ff) && valid_rd;

   always_comb begin
      op_in    = op_ff;
      sid_in   = sid_ff;
      pay_in   = pay_ff;
      idx_in   = idx_ff;
      range_in = range_ff;
      if (cmd.capture) begin
         op_in    = req_op;
         sid_in   = req_stream_id;
         pay_in   = pay_trim;
         idx_in   = idx_calc[IDX_W-1:0];
         range_in = idx_calc < ID_W'(NUM_IDS);
      end
   end

   always_comb begin
      fresh_in  = fresh_ff;
      head_in   = head_ff;
      tail_in   = tail_ff;
      fill_in   = fill_ff;
      alloc_got = 1'b0;
      aidx      = fresh_ff[IDX_W-1:0];
      rel_ok    = 1'b0;
      rsp_id_in  = rsp_id_ff;
      rsp_pay_in = rsp_pay_ff;
      rsp_ok_in  = rsp_ok_ff;
      unique case (op_ff)
         OP_ALLOC: begin
            if (fresh_ff < NUM_IDS_CNT) begin
               alloc_got = 1'b1;
               aidx      = fresh_ff[IDX_W-1:0];
            end else if (fill_ff != '0) begin
               alloc_got = 1'b1;
               aidx      = queue_rd;
            end
         end
         OP_LOOKUP: begin
            alloc_got = 1'b0;
         end
         OP_RELEASE: begin
            rel_ok = hit && (fill_ff < NUM_IDS_CNT);
         end
         default: begin
            alloc_got = 1'b0;
         end
      endcase

      if (cmd.commit) begin
         rsp_id_in  = sid_ff;
         rsp_pay_in = '0;
         rsp_ok_in  = 1'b0;
         unique case (op_ff)
            OP_ALLOC: begin
               rsp_id_in = alloc_got ? (base_id + ID_W'(aidx)) : '0;
               rsp_ok_in = alloc_got;
               if (fresh_ff < NUM_IDS_CNT) begin
                  fresh_in = fresh_ff + CNT_W'(1);
               end else if (alloc_got) begin
                  head_in = (head_ff == LAST_IDX) ? '0 : head_ff + IDX_W'(1);
                  fill_in = fill_ff - CNT_W'(1);
               end
            end
            OP_LOOKUP: begin
               rsp_pay_in = hit ? pay_out : '0;
               rsp_ok_in  = hit;
            end
            OP_RELEASE: begin
               rsp_ok_in = rel_ok;
               if (rel_ok) begin
                  tail_in = (tail_ff == LAST_IDX) ? '0 : tail_ff + IDX_W'(1);
                  fill_in = fill_ff + CNT_W'(1);
               end
            end
            default: begin
               rsp_ok_in = 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Memory write controls
   assign valid_we = cmd.commit && ((op_ff == OP_ALLOC && alloc_got) || rel_ok);
   assign valid_wd = (op_ff == OP_ALLOC);
   assign entry_wa = (op_ff == OP_ALLOC) ? aidx : idx_ff;
   assign pay_we   = cmd.commit && (op_ff == OP_ALLOC) && alloc_got;
   assign queue_we = cmd.commit && rel_ok;

   sia_ram #(
      .WIDTH (1),
      .DEPTH (NUM_IDS)
   ) u_valid_ram (
      .clock   (clock),
      .wr_en   (valid_we),
      .wr_addr (entry_wa),
      .wr_data (valid_wd),
      .rd_en   (cmd.read),
      .rd_addr (idx_ff),
      .rd_data (valid_rd)
   );

   sia_ram #(
      .WIDTH (PAYLOAD_BITS),
      .DEPTH (NUM_IDS)
   ) u_payload_ram (
      .clock   (clock),
      .wr_en   (pay_we),
      .wr_addr (entry_wa),
      .wr_data (pay_ff),
      .rd_en   (cmd.read),
      .rd_addr (idx_ff),
      .rd_data (pay_rd)
   );

   sia_ram #(
      .WIDTH (IDX_W),
      .DEPTH (NUM_IDS)
   ) u_queue_ram (
      .clock   (clock),
      .wr_en   (queue_we),
      .wr_addr (tail_ff),
      .wr_data (idx_ff),
      .rd_en   (cmd.read),
      .rd_addr (head_ff),
      .rd_data (queue_rd)
   );

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      sid_ff     <= sid_in;
      pay_ff     <= pay_in;
      idx_ff     <= idx_in;
      range_ff   <= range_in;
      rsp_id_ff  <= rsp_id_in;
      rsp_pay_ff <= rsp_pay_in;
      rsp_ok_ff  <= rsp_ok_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fresh_ff     <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fresh_ff     <= fresh_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign status.out_free    = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid         = rsp_valid_ff;
   assign rsp_result_id      = rsp_id_ff;
   assign rsp_result_payload = rsp_pay_ff;
   assign rsp_ok             = rsp_ok_ff;

endmodule

`default_nettype wire

// ----- rtl/core/stream_id_allocator.sv -----
// Flow: an accepted request is read from the tables and the free queue, then resolved and written
//   back, which loads the response register; resolve waits while the result register is held.
// The block takes no new request until the last one is resolved, set by the registered read of the
//   single-read-port tables and the write-back step; a held response stalls the next one's resolve.
// Reset: synchronous, active high; clears counters, queue pointers, state and base_id (to 16).
//   No clearing pass: entries at or above the fresh counter read as unused.
`timescale 1ns / 1ps
`default_nettype none

module stream_id_allocator
   import sia_pkg::*;
#(
   parameter int NUM_IDS      = NUM_IDS_DEF,
   parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,

   // Request channel
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,   // [19:0] stream_id, [51:20] payload
   input  wire logic [OP_W-1:0]        req_tuser,   // [1:0] op

   // Response channel
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0]      rsp_tdata,   // [19:0] result_id, [51:20] result_payload
   output logic                        rsp_tuser,   // [0] ok

   // Register port
   input  wire logic                   csr_psel,
   input  wire logic                   csr_penable,
   input  wire logic                   csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [CSR_DATA_W-1:0]  csr_pwdata,
   output logic      [CSR_DATA_W-1:0]  csr_prdata,
   output logic                        csr_pready
);

   cmd_type    cmd;
   status_type status;

   logic [ID_W-1:0]     base_id_ff;
   logic [ID_W-1:0]     base_id_in;
   logic                csr_wr;
   logic [ID_W-1:0]     rsp_result_id;
   logic [PAY_IO_W-1:0] rsp_result_payload;
   logic                rsp_ok;

   // Register writes complete in the access phase; the port never waits.
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // Decode on the word index; anything beyond the one register is dropped.
   always_comb begin
      base_id_in = base_id_ff;
      if (csr_wr && (csr_paddr[2] == CSR_REG_BASE_ID)) begin
         base_id_in = csr_pwdata[ID_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_id_ff <= BASE_ID_RESET;
      end else begin
         base_id_ff <= base_id_in;
      end
   end

   // Read back the base register, zero for unmapped words.
   assign csr_prdata = (csr_paddr[2] == CSR_REG_BASE_ID)
                       ? CSR_DATA_W'(base_id_ff) : '0;

   // Sequencer: accept, read, resolve.
   sia_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // Counter, free queue, entry tables and the response register.
   sia_datapath #(
      .NUM_IDS      (NUM_IDS),
      .PAYLOAD_BITS (PAYLOAD_BITS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_op             (op_type'(req_tuser)),
      .req_stream_id      (req_tdata[ID_W-1:0]),
      .req_payload        (req_tdata[ID_W+PAY_IO_W-1:ID_W]),
      .base_id            (base_id_ff),
      .rsp_tready         (rsp_tready),
      .rsp_tvalid         (rsp_tvalid),
      .rsp_result_id      (rsp_result_id),
      .rsp_result_payload (rsp_result_payload),
      .rsp_ok             (rsp_ok)
   );

   // Pack the response fields, low field first, zero pad to whole bytes.
   assign rsp_tdata = {{(RSP_TDATA_W - ID_W - PAY_IO_W){1'b0}},
                       rsp_result_payload, rsp_result_id};
   assign rsp_tuser = rsp_ok;

endmodule

`default_nettype wire

// ----- rtl/core/sia_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sia_checker
   import sia_pkg::*;
(
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_tvalid,
   input wire logic                   req_tready,
   input wire logic                   rsp_tvalid,
   input wire logic                   rsp_tready,
   input wire logic [RSP_TDATA_W-1:0] rsp_tdata,
   input wire logic                   rsp_tuser,
   input wire logic                   csr_psel,
   input wire logic                   csr_penable,
   input wire logic                   csr_pwrite,
   input wire logic [CSR_ADDR_W-1:0]  csr_paddr,
   input wire logic [CSR_DATA_W-1:0]  csr_pwdata,
   input wire logic [CSR_DATA_W-1:0]  csr_prdata,
   input wire logic                   csr_pready
);

   logic req_acc;
   logic csr_base_wr;
   logic csr_base_rd;

   assign req_acc     = req_tvalid && req_tready;
   assign csr_base_wr = csr_psel && csr_penable && csr_pwrite && csr_pready
                        && (csr_paddr[2] == CSR_REG_BASE_ID);
   assign csr_base_rd = csr_psel && !csr_pwrite && (csr_paddr[2] == CSR_REG_BASE_ID);

   // No response is pending right after reset
   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // A held response keeps its contents
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response changed");

   // One request in flight: not ready while an accepted request is read and resolved
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> !req_tready ##1 !req_tready)
      else $error("request accepted while another is in flight");

   // A failed response never carries a payload
   a_fail_no_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[ID_W+PAY_IO_W-1:ID_W] == '0)
      else $error("failed response with nonzero payload");

   // The base register reads back what was written
   a_base_readback: assert property (@(posedge clock) disable iff (reset)
      csr_base_wr ##1 csr_base_rd |->
         csr_prdata[ID_W-1:0] == $past(csr_pwdata[ID_W-1:0]))
      else $error("base_id readback mismatch");

endmodule

bind stream_id_allocator sia_checker u_sia_checker (.*);

`default_nettype wire
